### design/pdwt_pkg.sv
// ----------------------------------------------------------------------------
// pdwt_pkg
// Shared types, constants and the quarter-wave sine table for the polar
// detection to world tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pdwt_pkg;

  localparam int MAX_DETECTIONS_DEF = 2;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_REMOVE_DIST = 2'd0;
  localparam logic [1:0] CFG_RANGE_SCALE = 2'd1;
  localparam logic [1:0] CFG_EMPTY_Y     = 2'd2;

  localparam logic [11:0]        REMOVE_DIST_RST = 12'd650;
  localparam logic [3:0]         RANGE_SCALE_RST = 4'd10;
  localparam logic signed [15:0] EMPTY_Y_RST     = 16'sd1500;

  // heading modulo 360: bias to positive, reciprocal multiply, one correction-free step
  localparam int          DEG_FULL     = 360;
  localparam int          DEG_QUARTER  = 90;
  localparam int          DEG_HALF     = 180;
  localparam int          DEG_3QUARTER = 270;
  localparam int          HDG_BIAS     = 65880;              // 183 * 360
  localparam int          HDG_RECIP_SH = 27;
  localparam logic [18:0] HDG_RECIP    = 19'd372828;         // ceil(2^27 / 360)

  // sequencing of one request
  localparam logic [2:0] STEP_DROP = 3'd1;
  localparam logic [2:0] STEP_LAST = 3'd6;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pdwt_pt_t;

  typedef struct packed {
    logic drop;
    logic fill;
  } pdwt_ctl_t;

  typedef struct packed {
    logic     detected;
    pdwt_pt_t first;
    pdwt_pt_t second;
  } pdwt_res_t;

  // sin of 0..90 degrees, Q16
  localparam logic [16:0] SIN_Q16 [0:90] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

endpackage

`default_nettype wire

### design/pdwt_hdg.sv
// ----------------------------------------------------------------------------
// pdwt_hdg
// Heading in whole degrees (floor of raw / 16) reduced modulo 360.
// Two register stages: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module pdwt_hdg (
  input  wire logic               clk,
  input  wire logic signed [20:0] heading_raw,
  output logic        [8:0]       hmod
);

  logic        [18:0] biased;
  logic        [17:0] u_nxt;
  logic        [36:0] prod;
  logic        [17:0] u_r;
  logic        [8:0]  q_r;
  logic        [17:0] qmul;
  logic        [17:0] rem;
  logic        [8:0]  hmod_r;

  always_comb begin
    biased = {{2{heading_raw[20]}}, heading_raw[20:4]} + 19'(pdwt_pkg::HDG_BIAS);
    u_nxt  = biased[17:0];
    prod   = u_nxt * pdwt_pkg::HDG_RECIP;
    qmul   = 18'(q_r * 18'(pdwt_pkg::DEG_FULL));
    rem    = u_r - qmul;
  end

  always_ff @(posedge clk) begin
    u_r    <= u_nxt;
    q_r    <= prod[pdwt_pkg::HDG_RECIP_SH+8:pdwt_pkg::HDG_RECIP_SH];
    hmod_r <= rem[8:0];
  end

  assign hmod = hmod_r;

endmodule

`default_nettype wire

### design/pdwt_lane.sv
// ----------------------------------------------------------------------------
// pdwt_lane
// One detection to world coordinates: angle, sine/cosine lookup,
// range multiply, scale and saturating add. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pdwt_lane #(
  parameter int TRIG_FRAC_BITS = pdwt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic        [8:0]  hmod,
  input  wire logic        [9:0]  det_dist,
  input  wire logic        [8:0]  bearing,
  input  wire logic signed [15:0] robot_x,
  input  wire logic signed [15:0] robot_y,
  input  wire logic        [3:0]  range_scale,
  output pdwt_pkg::pdwt_pt_t      world
);

  localparam int F   = TRIG_FRAC_BITS;
  localparam int SH  = 16 - F;
  localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } quad_t;

  function automatic quad_t fold(input logic [8:0] a);
    quad_t q;
    if (a <= 9'(pdwt_pkg::DEG_QUARTER)) begin
      q.neg = 1'b0;
      q.idx = a[6:0];
    end else if (a <= 9'(pdwt_pkg::DEG_HALF)) begin
      q.neg = 1'b0;
      q.idx = 7'(9'(pdwt_pkg::DEG_HALF) - a);
    end else if (a <= 9'(pdwt_pkg::DEG_3QUARTER)) begin
      q.neg = 1'b1;
      q.idx = 7'(a - 9'(pdwt_pkg::DEG_HALF));
    end else begin
      q.neg = 1'b1;
      q.idx = 7'(9'(pdwt_pkg::DEG_FULL) - a);
    end
    return q;
  endfunction

  function automatic logic [F:0] scale_rom(input logic [6:0] idx);
    logic [17:0] s;
    s = {1'b0, pdwt_pkg::SIN_Q16[idx]} + 18'(RND);
    s = s >> SH;
    return s[F:0];
  endfunction

  function automatic logic signed [15:0] place(input logic signed [15:0] base,
                                               input logic neg, input logic [9:0] rel,
                                               input logic [3:0] sc);
    logic        [13:0] m;
    logic signed [17:0] off;
    logic signed [17:0] sum;
    m   = rel * sc;
    off = neg ? -$signed({4'b0, m}) : $signed({4'b0, m});
    sum = {{2{base[15]}}, base} + off;
    if (sum > 18'sd32767) return 16'sh7fff;
    if (sum < -18'sd32768) return 16'sh8000;
    return sum[15:0];
  endfunction

  logic [9:0]  t;
  logic [9:0]  t1;
  logic [8:0]  ang_nxt;
  logic [9:0]  angc_sum;
  logic [8:0]  angc_nxt;
  logic [8:0]  ang_r;
  logic [8:0]  angc_r;
  quad_t       qs;
  quad_t       qc;
  logic        sneg_r;
  logic        cneg_r;
  logic [F:0]  smag_r;
  logic [F:0]  cmag_r;
  logic [F+10:0] sprod;
  logic [F+10:0] cprod;
  logic        yneg_r;
  logic        xneg_r;
  logic [9:0]  yrel_r;
  logic [9:0]  xrel_r;
  pdwt_pkg::pdwt_pt_t world_r;

  always_comb begin
    t = {1'b0, bearing} + {1'b0, hmod};
    if (t >= 10'(2 * pdwt_pkg::DEG_FULL)) begin
      t1 = t - 10'(2 * pdwt_pkg::DEG_FULL);
    end else if (t >= 10'(pdwt_pkg::DEG_FULL)) begin
      t1 = t - 10'(pdwt_pkg::DEG_FULL);
    end else begin
      t1 = t;
    end
    ang_nxt  = (t1 == 10'd0) ? 9'd0 : 9'(10'(pdwt_pkg::DEG_FULL) - t1);
    angc_sum = {1'b0, ang_nxt} + 10'(pdwt_pkg::DEG_QUARTER);
    angc_nxt = (angc_sum >= 10'(pdwt_pkg::DEG_FULL)) ?
               9'(angc_sum - 10'(pdwt_pkg::DEG_FULL)) : angc_sum[8:0];
    qs    = fold(ang_r);
    qc    = fold(angc_r);
    sprod = det_dist * smag_r;
    cprod = det_dist * cmag_r;
  end

  always_ff @(posedge clk) begin
    ang_r     <= ang_nxt;
    angc_r    <= angc_nxt;
    sneg_r    <= qs.neg;
    cneg_r    <= qc.neg;
    smag_r    <= scale_rom(qs.idx);
    cmag_r    <= scale_rom(qc.idx);
    yneg_r    <= sneg_r;
    xneg_r    <= cneg_r;
    yrel_r    <= sprod[F+9:F];
    xrel_r    <= cprod[F+9:F];
    world_r.x <= place(robot_x, xneg_r, xrel_r, range_scale);
    world_r.y <= place(robot_y, yneg_r, yrel_r, range_scale);
  end

  assign world = world_r;

endmodule

`default_nettype wire

### design/pdwt_merge.sv
// ----------------------------------------------------------------------------
// pdwt_merge
// Holds the two tracked slots: range check against the robot, parking,
// shift of the second slot into the first, and fill from the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module pdwt_merge #(
  parameter int MAX_DETECTIONS = pdwt_pkg::MAX_DETECTIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pdwt_pkg::pdwt_ctl_t ctl,
  input  wire logic signed [15:0] robot_x,
  input  wire logic signed [15:0] robot_y,
  input  wire logic        [1:0]  det_count,
  input  wire logic        [11:0] remove_dist,
  input  wire logic signed [15:0] empty_y,
  input  wire pdwt_pkg::pdwt_pt_t world [MAX_DETECTIONS],
  output pdwt_pkg::pdwt_res_t     res
);

  pdwt_pkg::pdwt_pt_t s1_r, s1_nxt;
  pdwt_pkg::pdwt_pt_t s2_r, s2_nxt;
  pdwt_pkg::pdwt_pt_t parked;
  pdwt_pkg::pdwt_pt_t d1, d2;
  pdwt_pkg::pdwt_pt_t w2;
  logic        [31:0] sq_r [4];
  logic        [31:0] sq_nxt [4];
  logic signed [16:0] dd [4];
  logic signed [33:0] p [4];
  logic        [32:0] d2sum1, d2sum2;
  logic        [23:0] r2;
  logic        [1:0]  cnt_eff;

  generate
    if (MAX_DETECTIONS > 1) begin : g_two
      assign w2 = world[1];
    end else begin : g_one
      assign w2 = s2_r;
    end
  endgenerate

  always_comb begin
    dd[0] = {robot_x[15], robot_x} - {s1_r.x[15], s1_r.x};
    dd[1] = {robot_y[15], robot_y} - {s1_r.y[15], s1_r.y};
    dd[2] = {robot_x[15], robot_x} - {s2_r.x[15], s2_r.x};
    dd[3] = {robot_y[15], robot_y} - {s2_r.y[15], s2_r.y};
    for (int i = 0; i < 4; i++) begin
      p[i]      = dd[i] * dd[i];
      sq_nxt[i] = p[i][31:0];
    end
    d2sum1 = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    d2sum2 = {1'b0, sq_r[2]} + {1'b0, sq_r[3]};
    r2     = remove_dist * remove_dist;
    parked.x = 16'sd0;
    parked.y = empty_y;
    d1 = (d2sum1 > {9'd0, r2}) ? parked : s1_r;
    d2 = (d2sum2 > {9'd0, r2}) ? parked : s2_r;
    cnt_eff = (det_count > 2'(MAX_DETECTIONS)) ? 2'(MAX_DETECTIONS) : det_count;

    res.detected = (cnt_eff != 2'd0);
    res.first    = (cnt_eff >= 2'd1) ? world[0] : s1_r;
    res.second   = (cnt_eff >= 2'd2) ? w2 : s2_r;

    s1_nxt = s1_r;
    s2_nxt = s2_r;
    if (ctl.drop) begin
      if (d2.y != empty_y && d1.y == empty_y) begin
        s1_nxt = d2;
        s2_nxt = parked;
      end else begin
        s1_nxt = d1;
        s2_nxt = d2;
      end
    end else if (ctl.fill) begin
      s1_nxt = res.first;
      s2_nxt = res.second;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= sq_nxt[i];
    end
    if (!rst_n) begin
      s1_r.x <= 16'sd0;
      s1_r.y <= pdwt_pkg::EMPTY_Y_RST;
      s2_r.x <= 16'sd0;
      s2_r.y <= pdwt_pkg::EMPTY_Y_RST;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

### design/polar_detection_to_world_tracker.sv
// ----------------------------------------------------------------------------
// polar_detection_to_world_tracker
// Scan of up to two polar detections in, two tracked opponent positions out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one scan per request (counts, ranges, bearings, robot pose).
//   out_* : one result per scan: detected flag and both slot positions.
//   cfg_* : register writes (remove distance, range scale, empty y); always
//           ready, to be written only while no scan is in flight.
// Sequence:
//   A scan is taken, then worked through in steps: heading mod 360 by
//   reciprocal multiply, during which the slot unit does the range check
//   and shift, then each lane does angle, sine/cosine lookup, range
//   multiply and scale/add. The result register loads on the last step;
//   out_tvalid rises with it. in_tready drops while a scan is in work, so
//   a new scan is taken only once the last one has finished.
// Stall: a finished scan waits in its last step until the result register
//   is free; the result register holds until out_tready.
// Reset: rst_n (synchronous) clears the result valid, parks both slots at
//   (0, 1500) and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_detection_to_world_tracker #(
  parameter int MAX_DETECTIONS = pdwt_pkg::MAX_DETECTIONS_DEF,
  parameter int TRIG_FRAC_BITS = pdwt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // det_count[1:0], dist_a[11:2], bearing_a[20:12], dist_b[30:21],
  // bearing_b[39:31], robot_x[55:40], robot_y[71:56], heading_raw[92:72]
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // detected[0], first_x[16:1], first_y[32:17], second_x[48:33], second_y[64:49]
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [92:0] in_r;
  logic        busy_r, busy_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r;
  logic        finish;
  logic [11:0] remove_dist_r;
  logic [3:0]  range_scale_r;
  logic signed [15:0] empty_y_r;
  logic [8:0]  hmod;
  logic [9:0]  det_dist [MAX_DETECTIONS];
  logic [8:0]  bearing [MAX_DETECTIONS];
  pdwt_pkg::pdwt_pt_t  world [MAX_DETECTIONS];
  pdwt_pkg::pdwt_ctl_t ctl;
  pdwt_pkg::pdwt_res_t res;

  assign in_tready  = !busy_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign finish   = busy_r && (step_r == pdwt_pkg::STEP_LAST) && (!out_valid_r || out_tready);
  assign ctl.drop = busy_r && (step_r == pdwt_pkg::STEP_DROP);
  assign ctl.fill = finish;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (in_tvalid) begin
        busy_nxt = 1'b1;
        step_nxt = 3'd0;
      end
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (step_r != pdwt_pkg::STEP_LAST) begin
      step_nxt = step_r + 3'd1;
    end
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      step_r        <= 3'd0;
      out_valid_r   <= 1'b0;
      remove_dist_r <= pdwt_pkg::REMOVE_DIST_RST;
      range_scale_r <= pdwt_pkg::RANGE_SCALE_RST;
      empty_y_r     <= pdwt_pkg::EMPTY_Y_RST;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          pdwt_pkg::CFG_REMOVE_DIST: remove_dist_r <= cfg_data[11:0];
          pdwt_pkg::CFG_RANGE_SCALE: range_scale_r <= cfg_data[3:0];
          pdwt_pkg::CFG_EMPTY_Y:     empty_y_r     <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_r <= in_tdata[92:0];
    if (finish) out_data_r <= {7'd0, res.second.y, res.second.x,
                               res.first.y, res.first.x, res.detected};
  end

  pdwt_hdg u_hdg (
    .clk         (clk),
    .heading_raw ($signed(in_r[92:72])),
    .hmod        (hmod)
  );

  genvar gi;
  generate
    for (gi = 0; gi < MAX_DETECTIONS; gi++) begin : g_lane
      if (gi == 0) begin : g_a
        assign det_dist[gi] = in_r[11:2];
        assign bearing[gi]  = in_r[20:12];
      end else begin : g_b
        assign det_dist[gi] = in_r[30:21];
        assign bearing[gi]  = in_r[39:31];
      end
      pdwt_lane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lane (
        .clk         (clk),
        .hmod        (hmod),
        .det_dist    (det_dist[gi]),
        .bearing     (bearing[gi]),
        .robot_x     ($signed(in_r[55:40])),
        .robot_y     ($signed(in_r[71:56])),
        .range_scale (range_scale_r),
        .world       (world[gi])
      );
    end
  endgenerate

  pdwt_merge #(.MAX_DETECTIONS(MAX_DETECTIONS)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .robot_x     ($signed(in_r[55:40])),
    .robot_y     ($signed(in_r[71:56])),
    .det_count   (in_r[1:0]),
    .remove_dist (remove_dist_r),
    .empty_y     (empty_y_r),
    .world       (world),
    .res         (res)
  );

endmodule

`default_nettype wire

### design/pdwt_chk.sv
// ----------------------------------------------------------------------------
// pdwt_chk
// Port-level checks for the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdwt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second scan taken while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready) && in_tready)
    else $error("result appeared without a scan finishing");

endmodule

bind polar_detection_to_world_tracker pdwt_chk u_pdwt_chk (.*);

`default_nettype wire

### dv/polar_detection_to_world_tracker_tb.sv
// ----------------------------------------------------------------------------
// polar_detection_to_world_tracker_tb
// Scan stream check of the opponent tracker: directed table first, then
// random scans under several register settings. Each result is checked
// field by field with typed rows, else a cycle-free model of both slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polar_detection_to_world_tracker_tb;

  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam int         MAX_DET    = pdwt_pkg::MAX_DETECTIONS_DEF;
  localparam int         FRAC       = pdwt_pkg::TRIG_FRAC_BITS_DEF;
  localparam int         ROUND_SH   = 16 - FRAC;
  localparam int         STUCK_MAX  = 3000;
  localparam int         PHASE_LEN  = 190;

  localparam int SIN_TAB [0:90] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  typedef struct packed {
    logic signed [20:0] heading_raw;
    logic signed [15:0] robot_y;
    logic signed [15:0] robot_x;
    logic [8:0]         bearing_b;
    logic [9:0]         dist_b;
    logic [8:0]         bearing_a;
    logic [9:0]         dist_a;
    logic [1:0]         det_count;
  } scan_t;

  typedef struct packed {
    logic signed [15:0] second_y;
    logic signed [15:0] second_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_x;
    logic               detected;
  } track_t;

  typedef struct {
    int x;
    int y;
  } spot_t;

  typedef struct {
    scan_t  scan;
    bit     typed;
    track_t want;
  } row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = pdwt_pkg::CFG_REMOVE_DIST;
  logic [15:0] cfg_data   = '0;

  // shadow of the block's registers and slots
  int     remove_mm;
  int     scale_mm;
  int     empty_mark;
  spot_t  slot_one;
  spot_t  slot_two;

  track_t pending_tracks [$];
  row_t   plan [$];
  int     fault_count = 0;
  int     stuck_cycles = 0;
  bit     calm = 1'b0;
  int     walk_x = 0;
  int     walk_y = 0;

  polar_detection_to_world_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // sine of a whole degree 0..359 at FRAC fraction bits
  function automatic int deg_sin(int a);
    int q;
    if (a <= 90) q = SIN_TAB[a];
    else if (a <= 180) q = SIN_TAB[180 - a];
    else if (a <= 270) q = SIN_TAB[a - 180];
    else q = SIN_TAB[(360 - a) % 91];
    if (ROUND_SH > 0) q = (q + (1 << (ROUND_SH - 1))) >> ROUND_SH;
    return (a <= 180) ? q : -q;
  endfunction

  function automatic longint range_times_trig(int d, int t);
    longint p;
    p = longint'(d) * t;
    return (p < 0) ? -((-p) >>> FRAC) : (p >>> FRAC);
  endfunction

  function automatic spot_t polar_to_world(int d, int b, int hdeg, int rx, int ry);
    spot_t w;
    int    a;
    a = (-b - hdeg) % 360;
    if (a < 0) a += 360;
    w.x = sat16(rx + range_times_trig(d, deg_sin((a + 90) % 360)) * scale_mm);
    w.y = sat16(ry + range_times_trig(d, deg_sin(a)) * scale_mm);
    return w;
  endfunction

  function automatic spot_t drop_if_far(spot_t p, int rx, int ry);
    longint dx;
    longint dy;
    dx = rx - p.x;
    dy = ry - p.y;
    if (dx * dx + dy * dy > longint'(remove_mm) * remove_mm) begin
      p.x = 0;
      p.y = empty_mark;
    end
    return p;
  endfunction

  // advances the shadow slots by one scan and returns the tracker output
  function automatic track_t track_scan(scan_t s);
    track_t r;
    int     rx;
    int     ry;
    int     h;
    int     cnt;
    rx = s.robot_x;
    ry = s.robot_y;
    h = s.heading_raw;
    h = h >>> 4;
    slot_one = drop_if_far(slot_one, rx, ry);
    slot_two = drop_if_far(slot_two, rx, ry);
    if (slot_two.y != empty_mark && slot_one.y == empty_mark) begin
      slot_one = slot_two;
      slot_two.x = 0;
      slot_two.y = empty_mark;
    end
    cnt = (s.det_count > MAX_DET) ? MAX_DET : s.det_count;
    if (cnt >= 1) slot_one = polar_to_world(s.dist_a, s.bearing_a, h, rx, ry);
    if (cnt >= 2) slot_two = polar_to_world(s.dist_b, s.bearing_b, h, rx, ry);
    r.detected = (cnt > 0);
    r.first_x  = 16'(slot_one.x);
    r.first_y  = 16'(slot_one.y);
    r.second_x = 16'(slot_two.x);
    r.second_y = 16'(slot_two.y);
    return r;
  endfunction

  function automatic scan_t scan_of(int cnt, int da, int ba, int db, int bb,
                                    int rx, int ry, int hd);
    scan_t s;
    s.det_count   = cnt[1:0];
    s.dist_a      = da[9:0];
    s.bearing_a   = ba[8:0];
    s.dist_b      = db[9:0];
    s.bearing_b   = bb[8:0];
    s.robot_x     = rx[15:0];
    s.robot_y     = ry[15:0];
    s.heading_raw = hd[20:0];
    return s;
  endfunction

  function automatic track_t track_of(int det, int fx, int fy, int sx, int sy);
    track_t t;
    t.detected = det[0];
    t.first_x  = fx[15:0];
    t.first_y  = fy[15:0];
    t.second_x = sx[15:0];
    t.second_y = sy[15:0];
    return t;
  endfunction

  // mostly a robot wandering near its targets; some scans fully random
  function automatic scan_t random_scan();
    logic [95:0] raw;
    int          pick;
    int          cnt;
    int          hd;
    int          ba;
    int          bb;
    scan_t       s;
    if ($urandom_range(0, 99) < 12) begin
      raw = {$urandom, $urandom, $urandom};
      s = raw[92:0];
      return s;
    end
    if ($urandom_range(0, 99) < 3) begin
      walk_x = $urandom_range(0, 65535) - 32768;
      walk_y = $urandom_range(0, 65535) - 32768;
    end else begin
      walk_x = sat16(walk_x + int'($urandom_range(0, 128)) - 64);
      walk_y = sat16(walk_y + int'($urandom_range(0, 128)) - 64);
    end
    hd = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 11520) - 5760
                                     : $urandom_range(0, 2097151) - 1048576;
    pick = $urandom_range(0, 9);
    cnt = (pick < 3) ? 0 : (pick < 6) ? 1 : (pick < 9) ? 2 : 3;
    ba = ($urandom_range(0, 19) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    bb = ($urandom_range(0, 19) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    return scan_of(cnt,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120),
                   ba,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120),
                   bb, walk_x, walk_y, hd);
  endfunction

  task automatic send_scan(scan_t s, bit typed, track_t want);
    track_t guess;
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, s};
    do @(posedge clk); while (!in_tready);
    guess = track_scan(s);
    pending_tracks.push_back(typed ? want : guess);
  endtask

  task automatic load_regs(int rd, int sc, int ey, bit poke_spare);
    logic [1:0]  idx [$];
    logic [15:0] val [$];
    idx.push_back(pdwt_pkg::CFG_REMOVE_DIST); val.push_back(rd[15:0]);
    idx.push_back(pdwt_pkg::CFG_RANGE_SCALE); val.push_back(sc[15:0]);
    idx.push_back(pdwt_pkg::CFG_EMPTY_Y);     val.push_back(ey[15:0]);
    if (poke_spare) begin
      idx.push_back(CFG_SPARE);
      val.push_back(16'($urandom));
    end
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        pdwt_pkg::CFG_REMOVE_DIST: remove_mm  = val[i][11:0];
        pdwt_pkg::CFG_RANGE_SCALE: scale_mm   = val[i][3:0];
        pdwt_pkg::CFG_EMPTY_Y:     empty_mark = $signed(val[i]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    track_t seen;
    track_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[64:0];
      if (pending_tracks.size() == 0) begin
        $error("result with no request outstanding");
        fault_count++;
      end else begin
        want = pending_tracks.pop_front();
        check_field("detected", want.detected, seen.detected);
        check_field("first_x",  want.first_x,  seen.first_x);
        check_field("first_y",  want.first_y,  seen.first_y);
        check_field("second_x", want.second_x, seen.second_x);
        check_field("second_y", want.second_y, seen.second_y);
      end
    end
    out_tready <= calm || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_MAX) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    remove_mm  = pdwt_pkg::REMOVE_DIST_RST;
    scale_mm   = pdwt_pkg::RANGE_SCALE_RST;
    empty_mark = pdwt_pkg::EMPTY_Y_RST;
    slot_one   = '{0, empty_mark};
    slot_two   = '{0, empty_mark};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset state, then saturation at the edges of the field
    plan.push_back('{scan_of(0, 0, 0, 0, 0, 0, 1500, 0), 1'b1,
                     track_of(0, 0, 1500, 0, 1500)});
    plan.push_back('{scan_of(1, 0, 0, 0, 0, 0, 1500, 0), 1'b1,
                     track_of(1, 0, 1500, 0, 1500)});
    plan.push_back('{scan_of(2, 1023, 0, 1023, 180, 32767, 0, 0), 1'b1,
                     track_of(1, 32767, 0, 22537, 0)});
    plan.push_back('{scan_of(2, 1023, 180, 1023, 270, -32768, -32768, 0), 1'b1,
                     track_of(1, -32768, -32768, -32768, -22538)});
    plan.push_back('{scan_of(1, 1023, 270, 0, 0, 0, 32767, 0), 1'b1,
                     track_of(1, 0, 32767, 0, 1500)});
    // count above the limit, heading extremes and wrap, bearings past 359
    plan.push_back('{scan_of(3, 300, 45, 512, 300, 1000, -2000, 7200), 1'b0, '0});
    plan.push_back('{scan_of(2, 700, 359, 33, 511, -1200, 400, -1048576), 1'b0, '0});
    plan.push_back('{scan_of(2, 512, 360, 1, 0, 300, 300, 1048575), 1'b0, '0});
    plan.push_back('{scan_of(1, 40, 10, 0, 0, 0, 0, -1), 1'b0, '0});
    plan.push_back('{scan_of(1, 40, 10, 0, 0, 0, 0, 15), 1'b0, '0});
    // slot whose y equals the empty mark counts as empty and gets replaced
    plan.push_back('{scan_of(2, 50, 0, 50, 270, 0, 1500, 0), 1'b0, '0});
    plan.push_back('{scan_of(0, 0, 0, 0, 0, 0, 1500, 0), 1'b0, '0});
    // removal right at and just past the distance
    plan.push_back('{scan_of(1, 65, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{scan_of(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{scan_of(0, 0, 0, 0, 0, -1, 0, 0), 1'b0, '0});
    // first slot dropped, second shifts down
    plan.push_back('{scan_of(2, 65, 0, 10, 90, 0, 0, 0), 1'b0, '0});
    plan.push_back('{scan_of(0, 0, 0, 0, 0, -100, 0, 0), 1'b0, '0});
    plan.push_back('{scan_of(0, 0, 0, 0, 0, -100, 0, 0), 1'b0, '0});
    plan.push_back('{scan_of(2, 1023, 511, 1023, 511, 21845, -21846, 699050), 1'b0, '0});

    foreach (plan[i]) send_scan(plan[i].scan, plan[i].typed, plan[i].want);

    for (int ph = 1; ph <= 5; ph++) begin
      in_tvalid <= 1'b0;
      while (pending_tracks.size() != 0) @(posedge clk);
      calm = (ph == 2);
      case (ph)
        2: load_regs(4095, 15, 32767, 1'b0);
        3: load_regs(0, 1, -32768, 1'b1);
        4: load_regs($urandom_range(0, 4095), $urandom_range(1, 15),
                     $urandom_range(0, 65535) - 32768, 1'b1);
        5: load_regs(1000, 4, 0, 1'b0);
        default: ;
      endcase
      repeat (PHASE_LEN) send_scan(random_scan(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
